/* design/eafr_pkg.sv */
// Package for the escaped API frame receiver.
// Holds the shared token type, byte codes, result kinds and default sizes.
package eafr_pkg;

    localparam int unsigned HEADER_BYTES_DEF = 5;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] SUM_BASE   = 8'hFF;

    localparam logic [15:0] MAX_LENGTH_RST = 16'd256;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CSUM    = 2'd2;
    localparam logic [1:0] KIND_LENGTH  = 2'd3;

    // One unescaped byte moving between the front, the queue and the back.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_tok;

endpackage

/* design/eafr_front.sv */
// Front end of the escaped API frame receiver: accepts line bytes and removes escapes.
// Depends on eafr_pkg; feeds eafr_queue.
module eafr_front import eafr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_q_full,
    output t_tok       o_push
);

    logic r_esc;
    logic n_esc;
    logic w_accept;

    assign o_rx_ready = !i_q_full;
    assign w_accept   = i_rx_valid && !i_q_full;

    always_comb begin
        n_esc       = r_esc;
        o_push      = '0;
        o_push.data = r_esc ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;
        if (w_accept) begin
            // The escape byte itself is swallowed and only marks the next one.
            if (i_rx_byte == ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                n_esc        = 1'b0;
                o_push.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

endmodule

/* design/eafr_queue.sv */
// Short register queue of unescaped bytes between front and back end.
// Depends on eafr_pkg.
module eafr_queue import eafr_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_push,
    output logic o_full,
    output t_tok o_head,
    input  logic i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign w_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/eafr_back.sv */
// Back end of the escaped API frame receiver: frame state machine, checksum,
// counters and the result register. Depends on eafr_pkg.
module eafr_back import eafr_pkg::*; #(
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  t_tok        i_head,
    output logic        o_pop,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_frame_bytes,
    output logic [15:0] o_good_frames,
    output logic [15:0] o_error_frames,
    output logic [31:0] o_total_bytes
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_LEN_HI  = 3'd1;
    localparam logic [2:0] MODE_LEN_LO  = 3'd2;
    localparam logic [2:0] MODE_HEADER  = 3'd3;
    localparam logic [2:0] MODE_PAYLOAD = 3'd4;

    localparam logic [15:0] HDR_LAST = 16'(HEADER_BYTES);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_pcnt, n_pcnt;
    logic [15:0] r_good, n_good;
    logic [15:0] r_err, n_err;
    logic [31:0] r_total, n_total;
    logic [15:0] r_max;

    logic        r_res_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [15:0] r_fbytes, n_fbytes;
    logic        n_emit;

    logic [7:0]  w_b;
    logic [15:0] w_len_full;

    // A byte is taken whenever the result register is free or drains this cycle.
    assign o_pop      = i_head.valid && (!r_res_valid || i_res_ready);
    assign w_b        = i_head.data;
    assign w_len_full = {r_len[15:8], w_b};

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_pcnt   = r_pcnt;
        n_good   = r_good;
        n_err    = r_err;
        n_total  = r_total;
        n_emit   = 1'b0;
        n_kind   = KIND_PAYLOAD;
        n_data   = '0;
        n_fbytes = '0;
        unique case (r_mode)
            MODE_LEN_HI: begin
                n_len  = {w_b, 8'h00};
                n_mode = MODE_LEN_LO;
            end
            MODE_LEN_LO: begin
                n_len = w_len_full;
                if (w_len_full > r_max) begin
                    n_err  = r_err + 1'b1;
                    n_mode = MODE_IDLE;
                    n_emit = 1'b1;
                    n_kind = KIND_LENGTH;
                end else begin
                    n_mode = MODE_HEADER;
                end
            end
            MODE_HEADER: begin
                n_sum = r_sum + w_b;
                n_idx = r_idx + 1'b1;
                if (n_idx >= HDR_LAST) begin
                    n_mode = MODE_PAYLOAD;
                end
            end
            MODE_PAYLOAD: begin
                n_emit   = 1'b1;
                n_fbytes = r_pcnt;
                if (r_idx < r_len) begin
                    n_sum    = r_sum + w_b;
                    n_pcnt   = r_pcnt + 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_kind   = KIND_PAYLOAD;
                    n_data   = w_b;
                    n_fbytes = n_pcnt;
                end else begin
                    n_mode = MODE_IDLE;
                    if ((SUM_BASE - r_sum) == w_b) begin
                        n_good  = r_good + 1'b1;
                        n_total = r_total + 32'(r_pcnt);
                        n_kind  = KIND_GOOD;
                    end else begin
                        n_err  = r_err + 1'b1;
                        n_kind = KIND_CSUM;
                    end
                end
            end
            default: begin
                // Idle, and any code that cannot occur, waits for a delimiter.
                n_mode = MODE_IDLE;
                if (w_b == START_BYTE) begin
                    n_mode = MODE_LEN_HI;
                    n_len  = '0;
                    n_idx  = '0;
                    n_sum  = '0;
                    n_pcnt = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_pcnt      <= '0;
            r_good      <= '0;
            r_err       <= '0;
            r_total     <= '0;
            r_max       <= MAX_LENGTH_RST;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_mode  <= n_mode;
                r_len   <= n_len;
                r_idx   <= n_idx;
                r_sum   <= n_sum;
                r_pcnt  <= n_pcnt;
                r_good  <= n_good;
                r_err   <= n_err;
                r_total <= n_total;
            end
            if (o_pop) begin
                r_res_valid <= n_emit;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_kind        <= n_kind;
            r_data        <= n_data;
            r_fbytes      <= n_fbytes;
            o_good_frames  <= n_good;
            o_error_frames <= n_err;
            o_total_bytes  <= n_total;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_frame_bytes = r_fbytes;

endmodule

/* design/escaped_api_frame_receiver.sv */
// Escaped API frame receiver, top level. A line byte that causes a result is first
// written into the queue; the frame logic then loads the result register from it.
// Throughput: one line byte per cycle while no result is held; an escape byte is
// swallowed and gives no result. A held result stalls the back end, and once the
// queue is full rx ready drops until the result is taken.
// Reset: synchronous active low; clears the queue, escape flag, frame state and
// counters, and sets max_length to 256.
module escaped_api_frame_receiver import eafr_pkg::*; #(
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_frame_bytes,
    output logic [15:0] o_good_frames,
    output logic [15:0] o_error_frames,
    output logic [31:0] o_total_bytes
);

    t_tok w_push;
    t_tok w_head;
    logic w_full;
    logic w_pop;

    eafr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    eafr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    eafr_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_bytes  (o_frame_bytes),
        .o_good_frames  (o_good_frames),
        .o_error_frames (o_error_frames),
        .o_total_bytes  (o_total_bytes)
    );

endmodule

/* design/eafr_checker.sv */
// Port-level checks for the escaped API frame receiver, bound to the top level.
// Depends on eafr_pkg and escaped_api_frame_receiver.
module eafr_checker import eafr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_frame_bytes,
    input logic [15:0] o_good_frames
);

    // A stalled result stays valid and keeps its kind, data byte, frame bytes and good count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_frame_bytes) && $stable(o_good_frames))
        else $error("result changed while stalled");

    // Only payload results carry a data byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != KIND_PAYLOAD |-> o_data_byte == 8'h00)
        else $error("status result with nonzero data byte");

    // A rejected length reports no payload bytes.
    a_len_fbytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == KIND_LENGTH |-> o_frame_bytes == 16'h0000)
        else $error("length error with nonzero frame byte count");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule

bind escaped_api_frame_receiver eafr_checker u_eafr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_res_valid   (o_res_valid),
    .i_res_ready   (i_res_ready),
    .o_kind        (o_kind),
    .o_data_byte   (o_data_byte),
    .o_frame_bytes (o_frame_bytes),
    .o_good_frames (o_good_frames)
);

/* bench/testbench.sv */
// Self-checking bench for the escaped API frame receiver: drives escaped line bytes,
// predicts every payload byte and frame status, and checks them as they come out.
// Depends on eafr_pkg for the byte codes, result kinds and header size.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import eafr_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned STUCK_LIMIT  = 3000;
    localparam int unsigned ERROR_CAP    = 50;

    localparam logic [2:0] HUNT_START  = 3'd0;
    localparam logic [2:0] LEN_HIGH    = 3'd1;
    localparam logic [2:0] LEN_LOW     = 3'd2;
    localparam logic [2:0] HEADER_SUM  = 3'd3;
    localparam logic [2:0] PAYLOAD_SUM = 3'd4;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] fbytes;
        logic [15:0] good;
        logic [15:0] drops;
        logic [31:0] total;
    } t_frame_event;

    typedef struct {
        logic [7:0]  data;
        int unsigned gap;
    } t_line_item;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = MAX_LENGTH_RST;
    logic        i_rx_valid  = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_frame_bytes;
    logic [15:0] o_good_frames;
    logic [15:0] o_error_frames;
    logic [31:0] o_total_bytes;

    escaped_api_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_bytes  (o_frame_bytes),
        .o_good_frames  (o_good_frames),
        .o_error_frames (o_error_frames),
        .o_total_bytes  (o_total_bytes)
    );

    // Parser shadow state, updated on every accepted line byte.
    logic [2:0]   p_state          = HUNT_START;
    bit           esc_armed        = 1'b0;
    logic [15:0]  want_len         = '0;
    logic [15:0]  hdr_idx          = '0;
    logic [7:0]   csum             = '0;
    logic [15:0]  pay_count        = '0;
    logic [15:0]  good_tally       = '0;
    logic [15:0]  drop_tally       = '0;
    logic [31:0]  good_bytes_total = '0;
    logic [15:0]  len_limit        = MAX_LENGTH_RST;

    t_frame_event due_events[$];
    t_line_item   line_queue[$];

    int unsigned bytes_queued = 0;
    int unsigned fail_count   = 0;
    int unsigned results_seen = 0;
    int unsigned stuck_cycles = 0;
    int unsigned tx_wait      = 0;
    bit          gap_loaded   = 1'b0;
    t_line_item  next_item;
    int unsigned rx_stall     = 0;
    int unsigned hold_left    = 0;
    bit          rx_steady    = 1'b0;
    bit          rx_full_rate = 1'b0;
    t_frame_event seen_want;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_frame_event make_event(input logic [1:0] kind, input logic [7:0] data,
                                                input logic [15:0] fbytes);
        t_frame_event ev;
        ev.kind   = kind;
        ev.data   = data;
        ev.fbytes = fbytes;
        ev.good   = good_tally;
        ev.drops  = drop_tally;
        ev.total  = good_bytes_total;
        return ev;
    endfunction

    task automatic track_line_byte(input logic [7:0] raw);
        logic [7:0] b;
        b = raw;
        if (raw == ESC_BYTE) begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed) begin
            b = raw ^ ESC_XOR;
            esc_armed = 1'b0;
        end
        unique case (p_state)
            LEN_HIGH: begin
                want_len = {b, 8'h00};
                p_state = LEN_LOW;
            end
            LEN_LOW: begin
                want_len = want_len | {8'h00, b};
                if (want_len > len_limit) begin
                    drop_tally++;
                    p_state = HUNT_START;
                    due_events.push_back(make_event(KIND_LENGTH, 8'h00, 16'h0000));
                end else begin
                    p_state = HEADER_SUM;
                end
            end
            HEADER_SUM: begin
                csum += b;
                hdr_idx++;
                if (hdr_idx >= HEADER_BYTES_DEF) p_state = PAYLOAD_SUM;
            end
            PAYLOAD_SUM: begin
                if (hdr_idx < want_len) begin
                    csum += b;
                    pay_count++;
                    hdr_idx++;
                    due_events.push_back(make_event(KIND_PAYLOAD, b, pay_count));
                end else begin
                    p_state = HUNT_START;
                    if (8'(SUM_BASE - csum) == b) begin
                        good_tally++;
                        good_bytes_total += {16'h0000, pay_count};
                        due_events.push_back(make_event(KIND_GOOD, 8'h00, pay_count));
                    end else begin
                        drop_tally++;
                        due_events.push_back(make_event(KIND_CSUM, 8'h00, pay_count));
                    end
                end
            end
            default: begin
                p_state = HUNT_START;
                if (b == START_BYTE) begin
                    p_state = LEN_HIGH;
                    want_len = '0;
                    hdr_idx = '0;
                    csum = '0;
                    pay_count = '0;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            if (fail_count < ERROR_CAP) $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Line byte sender: each request waits out its own gap before it is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) track_line_byte(i_rx_byte);
            if (!i_rx_valid || o_rx_ready) begin
                if (line_queue.size() != 0 && !gap_loaded) begin
                    tx_wait = line_queue[0].gap;
                    gap_loaded = 1'b1;
                end
                if (line_queue.size() == 0 || tx_wait > 0) begin
                    if (tx_wait > 0) tx_wait--;
                    i_rx_valid <= 1'b0;
                end else begin
                    next_item = line_queue.pop_front();
                    gap_loaded = 1'b0;
                    i_rx_valid <= 1'b1;
                    i_rx_byte <= next_item.data;
                end
            end
        end
    end

    // Result receiver and checker. Two long hold-offs let the input side back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (due_events.size() == 0) begin
                    if (fail_count < ERROR_CAP) $error("result with no request pending: kind %0d",
                                                       o_kind);
                    fail_count++;
                end else begin
                    seen_want = due_events.pop_front();
                    compare_field("kind", seen_want.kind, o_kind);
                    compare_field("data_byte", seen_want.data, o_data_byte);
                    compare_field("frame_bytes", seen_want.fbytes, o_frame_bytes);
                    compare_field("good_frames", seen_want.good, o_good_frames);
                    compare_field("error_frames", seen_want.drops, o_error_frames);
                    compare_field("total_bytes", seen_want.total, o_total_bytes);
                end
                results_seen++;
                if (results_seen % 64 == 0) rx_steady = ($urandom_range(0, 2) == 0);
                if (results_seen == 200 || results_seen == 520) hold_left = 400;
                rx_stall = (rx_steady || rx_full_rate) ? 0 : $urandom_range(0, 14);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic push_line(input logic [7:0] b, input bit gap_on);
        t_line_item it;
        it.data = b;
        it.gap = gap_on ? $urandom_range(0, 14) : 0;
        line_queue.push_back(it);
        bytes_queued++;
    endtask

    // Sends one frame byte, escaping it when it must be escaped and now and then
    // when it need not be.
    task automatic push_data(input logic [7:0] b, input bit gap_on);
        if (b == ESC_BYTE || (b == START_BYTE && $urandom_range(0, 1) == 1)
                || $urandom_range(0, 7) == 0) begin
            push_line(ESC_BYTE, gap_on);
            push_line(b ^ ESC_XOR, gap_on);
        end else begin
            push_line(b, gap_on);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return ESC_BYTE;
            1: return START_BYTE;
            2: return ESC_BYTE ^ ESC_XOR;
            3: return START_BYTE ^ ESC_XOR;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 39))
            0, 1, 2, 3: return 16'($urandom_range(0, HEADER_BYTES_DEF));
            4: begin
                if (len_limit <= 300) return len_limit;
                return 16'($urandom_range(6, 21));
            end
            5, 6, 7: begin
                if (len_limit == 16'hFFFF) return 16'($urandom_range(6, 21));
                if ($urandom_range(0, 1) == 1) return 16'(len_limit + 1);
                return 16'($urandom_range(len_limit + 1, 65535));
            end
            default: return 16'($urandom_range(HEADER_BYTES_DEF, HEADER_BYTES_DEF + 12));
        endcase
    endfunction

    // keep < 0 sends the whole frame; otherwise the frame stops after keep body bytes.
    task automatic send_frame(input logic [15:0] len, input bit good, input bit gap_on,
                              input int keep);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned body;
        sum = '0;
        if ($urandom_range(0, 7) == 0) begin
            push_line(ESC_BYTE, gap_on);
            push_line(START_BYTE ^ ESC_XOR, gap_on);
        end else begin
            push_line(START_BYTE, gap_on);
        end
        push_data(len[15:8], gap_on);
        push_data(len[7:0], gap_on);
        if (len > len_limit) return;
        body = (len > HEADER_BYTES_DEF) ? len : HEADER_BYTES_DEF;
        for (int i = 0; i < body; i++) begin
            if (keep >= 0 && i >= keep) return;
            b = pick_byte();
            sum += b;
            push_data(b, gap_on);
        end
        b = SUM_BASE - sum;
        if (!good) b ^= 8'($urandom_range(1, 255));
        push_data(b, gap_on);
    endtask

    task automatic send_random_traffic(input int unsigned n);
        int unsigned stop_at;
        bit          gap_on;
        logic [7:0]  b;
        stop_at = bytes_queued + n;
        while (bytes_queued < stop_at) begin
            gap_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 19))
                0: begin
                    // Idle noise; escape and delimiter codes stay out so the
                    // parser resynchronizes on the next frame.
                    repeat ($urandom_range(1, 3)) begin
                        b = 8'($urandom);
                        if (b == ESC_BYTE || b == START_BYTE) b = 8'h00;
                        push_line(b, gap_on);
                    end
                end
                1: begin
                    // Broken frame; only where a stray length cannot be huge.
                    if (len_limit <= 1024)
                        send_frame(pick_length(), 1'b1, gap_on, $urandom_range(0, 6));
                end
                default: send_frame(pick_length(), $urandom_range(0, 3) != 0, gap_on, -1);
            endcase
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (line_queue.size() != 0 || i_rx_valid || due_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_length_limit(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_limit = value;
    endtask

    initial begin
        logic [7:0] hdr_bytes [5];
        logic [7:0] sum;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset limit.
        push_line(8'h00, 1'b1);
        push_line(8'hFF, 1'b1);
        // An escaped delimiter is not a start, but a double escape before 0x5E is.
        push_line(ESC_BYTE, 1'b1);
        push_line(START_BYTE, 1'b1);
        push_line(ESC_BYTE, 1'b1);
        push_line(ESC_BYTE, 1'b1);
        push_line(START_BYTE ^ ESC_XOR, 1'b1);
        push_data(8'h00, 1'b1);
        push_data(8'h06, 1'b1);
        hdr_bytes = '{8'h00, 8'hFF, ESC_BYTE, 8'h11, START_BYTE};
        sum = '0;
        foreach (hdr_bytes[i]) begin
            push_data(hdr_bytes[i], 1'b1);
            sum += hdr_bytes[i];
        end
        // A bare delimiter inside the frame is payload.
        push_line(START_BYTE, 1'b1);
        sum += START_BYTE;
        push_data(SUM_BASE - sum, 1'b1);
        send_frame(16'hFFFF, 1'b1, 1'b1, -1);
        send_frame(16'h0000, 1'b0, 1'b1, -1);
        wait_drained();

        set_length_limit(16'd256);
        send_random_traffic(150);
        wait_drained();
        set_length_limit(16'h0000);
        send_random_traffic(100);
        wait_drained();
        set_length_limit(16'hFFFF);
        send_random_traffic(150);
        wait_drained();
        set_length_limit(16'(HEADER_BYTES_DEF));
        send_random_traffic(100);
        wait_drained();
        set_length_limit(16'(HEADER_BYTES_DEF + 1));
        send_random_traffic(100);
        wait_drained();
        set_length_limit(16'($urandom_range(7, 600)));
        send_random_traffic(150);
        wait_drained();

        // Back-to-back oversize frames at full rate, each rejected at its length.
        set_length_limit(16'h0000);
        rx_full_rate = 1'b1;
        repeat (20) begin
            push_line(START_BYTE, 1'b0);
            push_line(8'h00, 1'b0);
            push_line(8'h01, 1'b0);
        end
        wait_drained();
        rx_full_rate = 1'b0;

        set_length_limit(16'd256);
        send_random_traffic(60);
        wait_drained();

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/eafr_pkg.sv
design/eafr_front.sv
design/eafr_queue.sv
design/eafr_back.sv
design/escaped_api_frame_receiver.sv
design/eafr_checker.sv
bench/testbench.sv
